/* sv/oli_pkg.sv */
package oli_pkg;

  // default sizes for the top level parameters
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed field widths of the request and result ports
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned MAX_DW   = 64;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_REAR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_REAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // list operation picked by the decoder
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DEL
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic start;
    logic rd_en;
    logic rd_here;
    logic shift_wr;
    logic value_wr;
    logic cap_removed;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic ins_done;
    logic del_done;
  } sts_t;

endpackage

/* sv/oli_ram.sv */
module oli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/oli_ctrl.sv */
module oli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  oli_pkg::sts_t sts_i,
  output oli_pkg::cmd_t cmd_o
);
  import oli_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.start = 1'b1;
        case (sts_i.op)
          OP_INS:  state_d = S_INS_CHK;
          OP_DEL:  state_d = S_DEL_RD;
          default: state_d = S_FINISH;
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.ins_done) begin
          cmd_o.value_wr = 1'b1;
          state_d        = S_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_INS_CHK;
      end
      S_DEL_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_here = 1'b1;
        state_d       = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd_o.cap_removed = 1'b1;
        state_d           = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (sts_i.del_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_DEL_CHK;
      end
      S_FINISH: begin
        // wait until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* sv/oli_dpath.sv */
module oli_dpath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  oli_pkg::cmd_t                     cmd_i,
  output oli_pkg::sts_t                     sts_o,
  input  logic [oli_pkg::REQ_W-1:0]         req_type_i,
  input  logic [oli_pkg::POS_W-1:0]         position_i,
  input  logic [oli_pkg::VALUE_W-1:0]       value_i,
  output logic [oli_pkg::VALUE_W-1:0]       removed_value_o,
  output logic [oli_pkg::STATUS_W-1:0]      status_o,
  output logic [oli_pkg::COUNT_W-1:0]       entry_count_o,
  output logic                              is_empty_o
);
  import oli_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [REQ_W-1:0]      req_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [DATA_WIDTH-1:0] removed_q;
  logic [VALUE_W-1:0]    out_removed_q;
  logic [STATUS_W-1:0]   out_status_q;

  logic [MAX_DW-1:0]     value_wide;
  logic [MAX_DW-1:0]     removed_wide;
  logic [PW-1:0]         pos_w, cnt_w, pos_m1, depth_w;
  logic [CW-1:0]         cnt_m1;
  logic                  is_full;
  op_e                   op;
  logic [STATUS_W-1:0]   status;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         src;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;

  assign value_wide   = MAX_DW'(value_i);
  assign removed_wide = MAX_DW'(removed_q);

  assign pos_w   = PW'(pos_q);
  assign cnt_w   = PW'(count_q);
  assign pos_m1  = pos_w - PW'(1);
  assign depth_w = PW'(DEPTH);
  assign cnt_m1  = count_q - CW'(1);
  assign is_full = (cnt_w >= depth_w);

  // request decode: status, operation and target slot
  always_comb begin
    op     = OP_NONE;
    status = ST_OK;
    idx    = '0;
    case (req_q)
      REQ_ADD_FRONT, REQ_ADD_REAR: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          op  = OP_INS;
          idx = (req_q == REQ_ADD_FRONT) ? '0 : count_q[AW-1:0];
        end
      end
      REQ_REM_FRONT, REQ_REM_REAR: begin
        if (cnt_w == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          op  = OP_DEL;
          idx = (req_q == REQ_REM_FRONT) ? '0 : cnt_m1[AW-1:0];
        end
      end
      REQ_INSERT: begin
        if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
          status = ST_RANGE;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          op  = OP_INS;
          idx = pos_m1[AW-1:0];
        end
      end
      REQ_DELETE: begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          status = ST_RANGE;
        end else begin
          op  = OP_DEL;
          idx = pos_m1[AW-1:0];
        end
      end
      default: begin
        op     = OP_NONE;
        status = ST_OK;
      end
    endcase
  end

  // shift source: one slot toward the hole being closed or opened
  assign src = (op == OP_DEL) ? ptr_q + AW'(1) : ptr_q - AW'(1);

  assign sts_o.op       = op;
  assign sts_o.ins_done = (ptr_q == idx);
  assign sts_o.del_done = (PW'(ptr_q) + PW'(1) == cnt_w);

  // entry store port selection
  assign ram_we    = cmd_i.shift_wr | cmd_i.value_wr;
  assign ram_waddr = cmd_i.value_wr ? idx : ptr_q;
  assign ram_wdata = cmd_i.value_wr ? val_q : rdata;
  assign ram_raddr = cmd_i.rd_here ? ptr_q : src;

  oli_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // shift pointer
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.start) begin
      ptr_d = (op == OP_INS) ? count_q[AW-1:0] : idx;
    end else if (cmd_i.shift_wr) begin
      ptr_d = src;
    end
  end

  // entry count after the request
  always_comb begin
    count_d = count_q;
    if (cmd_i.finish) begin
      case (op)
        OP_INS:  count_d = count_q + CW'(1);
        OP_DEL:  count_d = cnt_m1;
        default: count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // request, pointer and result payload registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load_req) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= value_wide[DATA_WIDTH-1:0];
    end
    if (cmd_i.cap_removed) begin
      removed_q <= rdata;
    end
    if (cmd_i.finish) begin
      out_status_q  <= status;
      out_removed_q <= (op == OP_DEL) ? removed_wide[VALUE_W-1:0] : '0;
    end
  end

  assign removed_value_o = out_removed_q;
  assign status_o        = out_status_q;
  assign entry_count_o   = cnt_w[COUNT_W-1:0];
  assign is_empty_o      = (count_q == '0);

endmodule

/* sv/ordered_list_insert_delete.sv */
// a rejected or unused request goes straight to the result; an add or insert shifts n entries
// and then writes the value, a remove or delete captures the removed entry and then shifts n entries,
// n = entries shifted (one read and one write of the single-port-pair entry store per shifted entry)
// one request in flight; the next input transfer is taken only after the result
// is loaded into the output register, which holds it until its transfer
// reset (async, active low) empties the list; entry store contents are not cleared
module ordered_list_insert_delete #(
  parameter int unsigned DEPTH      = oli_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = oli_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [oli_pkg::REQ_W-1:0]    req_type_i,
  input  logic [oli_pkg::POS_W-1:0]    position_i,
  input  logic [oli_pkg::VALUE_W-1:0]  value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [oli_pkg::VALUE_W-1:0]  removed_value_o,
  output logic [oli_pkg::STATUS_W-1:0] status_o,
  output logic [oli_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                         is_empty_o
);
  import oli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing of each request
  oli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // decode, entry store and result payload
  oli_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o)
  );

endmodule

/* sv/oli_checker.sv */
module oli_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [oli_pkg::REQ_W-1:0]    req_type_i,
  input logic [oli_pkg::POS_W-1:0]    position_i,
  input logic [oli_pkg::VALUE_W-1:0]  value_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [oli_pkg::VALUE_W-1:0]  removed_value_o,
  input logic [oli_pkg::STATUS_W-1:0] status_o,
  input logic [oli_pkg::COUNT_W-1:0]  entry_count_o,
  input logic                         is_empty_o
);
  import oli_pkg::*;

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(req_type_i)
      && $stable(position_i) && $stable(value_i))
    else $error("request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(removed_value_o)
      && $stable(status_o) && $stable(entry_count_o))
    else $error("result changed while stalled");

  // empty flag agrees with the count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  // underflow only on an empty list
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNDERFLOW |-> entry_count_o == '0)
    else $error("underflow with entries stored");

  // a failed request returns no value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> removed_value_o == '0)
    else $error("removed value on failed request");

endmodule

bind ordered_list_insert_delete oli_checker u_oli_checker (.*);
